// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/fanm_pkg.sv =====
`timescale 1ns / 1ps

package fanm_pkg;

  localparam int WORDS = 8;
  localparam int IDX_W = $clog2(WORDS);

  localparam logic [31:0] P_WORD0   = 32'hFFFFFC2F;
  localparam logic [31:0] P_WORD1   = 32'hFFFFFFFE;
  localparam logic [31:0] P_WORD_HI = 32'hFFFFFFFF;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_NEG = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] a_word;
    logic [31:0] b_word;
  } in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        cin;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        cout;
  } alu_rsp_t;

  function automatic logic [31:0] prime_word(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    case (idx)
      IDX_W'(0): w = P_WORD0;
      IDX_W'(1): w = P_WORD1;
      default:   w = P_WORD_HI;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/fanm_word_alu.sv =====
`timescale 1ns / 1ps

module fanm_word_alu (
  input  fanm_pkg::alu_req_t req,
  output fanm_pkg::alu_rsp_t rsp
);

  // Subtraction runs as x + ~y + ~borrow; the adder's carry is the inverted borrow, so cout gives the borrow.
  logic [31:0] y_eff;
  logic        c_eff;
  logic [32:0] sum;

  assign y_eff = req.sub ? ~req.y : req.y;
  assign c_eff = req.sub ? ~req.cin : req.cin;
  assign sum   = {1'b0, req.x} + {1'b0, y_eff} + {32'd0, c_eff};

  assign rsp.res  = sum[31:0];
  assign rsp.cout = req.sub ? ~sum[32] : sum[32];

endmodule

// ===== sv/field_add_negate_mod_p_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload            Handshake
// in       input      fanm_pkg::in_t     in_valid / in_stall
// out      output     fanm_pkg::out_t    out_valid / out_stall
// An add word passes through accept, sum step and difference step, and a negate word
// through accept and difference step, all through one shared 32-bit add/subtract unit.
// After the eighth word, eight result words follow, one per cycle when out is not stalled.
// Synchronous active-low reset clears the sequencer; the word buffers are not cleared.

`include "assert_macros.svh"

module field_add_negate_mod_p_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fanm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fanm_pkg::out_t out_data
);

  localparam int IDX_W = fanm_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(fanm_pkg::WORDS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_DIFF = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] oi_r, oi_nxt;
  logic             op_r, op_nxt;
  logic             carry_r, carry_nxt;
  logic             borrow_r, borrow_nxt;
  logic             nz_r, nz_nxt;
  logic             take_diff_r, take_diff_nxt;
  logic             zero_r, zero_nxt;
  logic [31:0]      a_r, b_r, t_r;
  logic [31:0]      sum_mem_r [fanm_pkg::WORDS];
  logic [31:0]      diff_mem_r [fanm_pkg::WORDS];

  fanm_pkg::alu_req_t alu_req;
  fanm_pkg::alu_rsp_t alu_rsp;
  logic               in_accept;
  logic               out_accept;

  fanm_word_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == S_EMIT);
  assign out_accept = out_valid && !out_stall;

  assign out_data.result_word = zero_r ? 32'd0 :
                                (take_diff_r ? diff_mem_r[oi_r] : sum_mem_r[oi_r]);
  assign out_data.last_word   = (oi_r == LAST_IDX);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    oi_nxt        = oi_r;
    op_nxt        = op_r;
    carry_nxt     = carry_r;
    borrow_nxt    = borrow_r;
    nz_nxt        = nz_r;
    take_diff_nxt = take_diff_r;
    zero_nxt      = zero_r;
    alu_req.x     = a_r;
    alu_req.y     = b_r;
    alu_req.cin   = carry_r;
    alu_req.sub   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (idx_r == '0) begin
            op_nxt     = in_data.mode;
            carry_nxt  = 1'b0;
            borrow_nxt = 1'b0;
            nz_nxt     = 1'b0;
          end
          state_nxt = (op_nxt == fanm_pkg::MODE_ADD) ? S_SUM : S_DIFF;
        end
      end
      S_SUM: begin
        carry_nxt = alu_rsp.cout;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.cin = borrow_r;
        if (op_r == fanm_pkg::MODE_NEG) begin
          alu_req.x = fanm_pkg::prime_word(idx_r);
          alu_req.y = a_r;
          if (a_r != 32'd0) begin
            nz_nxt = 1'b1;
          end
        end else begin
          alu_req.x = t_r;
          alu_req.y = fanm_pkg::prime_word(idx_r);
        end
        borrow_nxt = alu_rsp.cout;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          oi_nxt    = '0;
          state_nxt = S_EMIT;
          if (op_r == fanm_pkg::MODE_NEG) begin
            take_diff_nxt = 1'b1;
            zero_nxt      = !nz_nxt;
          end else begin
            take_diff_nxt = carry_r || !alu_rsp.cout;
            zero_nxt      = 1'b0;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_accept) begin
          if (oi_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            oi_nxt = oi_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      oi_r        <= '0;
      op_r        <= 1'b0;
      carry_r     <= 1'b0;
      borrow_r    <= 1'b0;
      nz_r        <= 1'b0;
      take_diff_r <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      oi_r        <= oi_nxt;
      op_r        <= op_nxt;
      carry_r     <= carry_nxt;
      borrow_r    <= borrow_nxt;
      nz_r        <= nz_nxt;
      take_diff_r <= take_diff_nxt;
      zero_r      <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_r <= in_data.a_word;
      b_r <= in_data.b_word;
    end
    if (state_r == S_SUM) begin
      t_r              <= alu_rsp.res;
      sum_mem_r[idx_r] <= alu_rsp.res;
    end
    if (state_r == S_DIFF) begin
      diff_mem_r[idx_r] <= alu_rsp.res;
    end
  end

  `ASSERT_IMPL(a_no_input_while_emit, out_valid, in_stall)
  `ASSERT_NEXT(a_sum_then_diff, state_r == S_SUM, state_r == S_DIFF)
  `ASSERT_NEXT(a_last_ends_burst, out_accept && out_data.last_word, !out_valid)
  `ASSERT_NEXT(a_first_word_clears, in_accept && (idx_r == '0), !carry_r && !borrow_r)

endmodule

// ===== sim/field_add_negate_mod_p_top_test.sv =====
`timescale 1ns / 1ps

module field_add_negate_mod_p_top_test;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_OPS = 11;
  localparam logic [255:0] PRIME = {{6{fanm_pkg::P_WORD_HI}}, fanm_pkg::P_WORD1,
                                    fanm_pkg::P_WORD0};

  class mod_p_scoreboard;
    fanm_pkg::out_t result_q[$];
    logic [31:0] sum_w[fanm_pkg::WORDS];
    logic [31:0] diff_w[fanm_pkg::WORDS];
    logic carry;
    logic borrow;
    logic a_nonzero;
    logic op;
    int word_cnt;
    int mismatches;

    function new();
      carry = 1'b0;
      borrow = 1'b0;
      a_nonzero = 1'b0;
      op = fanm_pkg::MODE_ADD;
      word_cnt = 0;
      mismatches = 0;
    endfunction

    function void note_word(fanm_pkg::in_t w);
      logic [32:0] s;
      logic [32:0] d;
      logic [31:0] pw;
      logic take_diff;
      fanm_pkg::out_t r;
      if (word_cnt == 0) begin
        op = w.mode;
        carry = 1'b0;
        borrow = 1'b0;
        a_nonzero = 1'b0;
      end
      pw = (word_cnt == 0) ? fanm_pkg::P_WORD0 :
           (word_cnt == 1) ? fanm_pkg::P_WORD1 : fanm_pkg::P_WORD_HI;
      if (op == fanm_pkg::MODE_ADD) begin
        s = {1'b0, w.a_word} + {1'b0, w.b_word} + {32'd0, carry};
        sum_w[word_cnt] = s[31:0];
        carry = s[32];
        d = {1'b0, s[31:0]} - {1'b0, pw} - {32'd0, borrow};
      end else begin
        if (w.a_word != 32'd0) begin
          a_nonzero = 1'b1;
        end
        d = {1'b0, pw} - {1'b0, w.a_word} - {32'd0, borrow};
      end
      diff_w[word_cnt] = d[31:0];
      borrow = d[32];
      if (word_cnt != fanm_pkg::WORDS - 1) begin
        word_cnt++;
        return;
      end
      word_cnt = 0;
      take_diff = carry || !borrow;
      for (int i = 0; i < fanm_pkg::WORDS; i++) begin
        if (op == fanm_pkg::MODE_ADD) begin
          r.result_word = take_diff ? diff_w[i] : sum_w[i];
        end else begin
          r.result_word = a_nonzero ? diff_w[i] : 32'd0;
        end
        r.last_word = (i == fanm_pkg::WORDS - 1);
        result_q.push_back(r);
      end
    endfunction

    function void check_word(fanm_pkg::out_t got);
      fanm_pkg::out_t want;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word %h last %b", got.result_word, got.last_word);
        end
        return;
      end
      want = result_q.pop_front();
      if (got.result_word !== want.result_word || got.last_word !== want.last_word) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected %h last %b, got %h last %b",
                   want.result_word, want.last_word, got.result_word, got.last_word);
        end
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fanm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fanm_pkg::out_t out_data;

  logic in_idle_on = 1'b1;
  logic out_idle_on = 1'b1;
  logic hold_request = 1'b0;
  int cycles = 0;
  mod_p_scoreboard sb = new();

  field_add_negate_mod_p_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("field_add_negate_mod_p_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_word(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_word(out_data);
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= out_idle_on && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic send_word(input fanm_pkg::in_t w);
    int gap;
    gap = 0;
    while (in_idle_on && $urandom_range(99) < 17) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_op(input logic mode, input logic [255:0] a, input logic [255:0] b);
    fanm_pkg::in_t w;
    for (int i = 0; i < fanm_pkg::WORDS; i++) begin
      w.mode = (i == 0) ? mode : logic'($urandom_range(1));
      w.a_word = a[32 * i +: 32];
      w.b_word = b[32 * i +: 32];
      send_word(w);
    end
  endtask

  function automatic logic [255:0] random_wide();
    logic [255:0] v;
    for (int i = 0; i < fanm_pkg::WORDS; i++) begin
      v[32 * i +: 32] = $urandom;
    end
    return v;
  endfunction

  function automatic logic [255:0] random_operand();
    logic [255:0] v;
    case ($urandom_range(5))
      0: v = PRIME - 256'($urandom_range(1000));
      1: v = PRIME + 256'($urandom_range(1000));
      2: begin
        for (int i = 0; i < fanm_pkg::WORDS; i++) begin
          case ($urandom_range(2))
            0: v[32 * i +: 32] = 32'd0;
            1: v[32 * i +: 32] = 32'hFFFFFFFF;
            default: v[32 * i +: 32] = $urandom;
          endcase
        end
      end
      3: v = '0;
      4: v = 256'($urandom);
      default: v = random_wide();
    endcase
    return v;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(fanm_pkg::MODE_ADD, PRIME - 256'd1, 256'd1);
    send_op(fanm_pkg::MODE_ADD, '1, '1);
    send_op(fanm_pkg::MODE_NEG, '0, '1);
    send_op(fanm_pkg::MODE_NEG, '1, '0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      in_idle_on = !(n >= 6 && n <= 10);
      out_idle_on = in_idle_on;
      if (n == 4) begin
        hold_request = 1'b1;
      end
      send_op(logic'($urandom_range(1)), random_operand(), random_operand());
    end
    in_valid <= 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("field_add_negate_mod_p_top regression: pass");
    end else begin
      $display("field_add_negate_mod_p_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fanm_pkg.sv
sv/fanm_word_alu.sv
sv/field_add_negate_mod_p_top.sv
sim/field_add_negate_mod_p_top_test.sv
